// File: hdl/fbom_pkg.sv
package fbom_pkg;

  // command codes as they arrive on the input word
  localparam logic [2:0] CMD_FRAME_DONE = 3'd0;
  localparam logic [2:0] CMD_REQ_ANY    = 3'd1;
  localparam logic [2:0] CMD_REQ_INDEX  = 3'd2;
  localparam logic [2:0] CMD_RELEASE    = 3'd3;
  localparam logic [2:0] CMD_START      = 3'd4;
  localparam logic [2:0] CMD_STOP       = 3'd5;

  // register indexes on the config port
  localparam logic [1:0] REG_BUFFERS_IN_USE   = 2'd0;
  localparam logic [1:0] REG_AUTO_QUEUE_COUNT = 2'd1;
  localparam logic [1:0] REG_KEEP_RELEASED    = 2'd2;

  localparam logic [3:0] RST_BUFFERS_IN_USE   = 4'd8;
  localparam logic [3:0] RST_AUTO_QUEUE_COUNT = 4'd3;
  localparam logic       RST_KEEP_RELEASED    = 1'b1;

  localparam int SCAN_ITEMS_MAX = 8;
  localparam int CMDQ_DEPTH     = 2;

  typedef enum logic [2:0] {
    OP_FRAME_DONE,
    OP_REQ_ANY,
    OP_REQ_INDEX,
    OP_RELEASE,
    OP_START,
    OP_STOP,
    OP_NOP,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    KIND_QUEUE  = 2'd0,
    KIND_NOTIFY = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RETRY     = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SCAN,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] idx;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0] active;
    logic [3:0] auto_queue_count;
    logic       keep_released;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] out_index;
    logic [3:0] handle;
    status_e    status;
    logic [3:0] queued_now;
    logic       last;
  } res_t;

endpackage

// File: hdl/frame_buffer_ownership_manager.sv
// A command passes the back-end states idle, exec, an optional rescan and done,
//   and waits out result stalls; the rescan visits at most the active buffers.
// The back-end sequencer visits one buffer flag pair per cycle unless a result
//   stall holds it, and takes the next command only after its done word.
// A 2-entry command queue lets the next word be taken while one executes.
// Reset (sync, active high): all buffers unqueued and released, counters 0.
module frame_buffer_ownership_manager #(
  parameter int MAX_BUFFERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command words
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [2:0]  command,
  input  logic [2:0]  buffer_index,
  // result words
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  kind,
  output logic [2:0]  out_index,
  output logic [3:0]  handle,
  output logic [1:0]  status,
  output logic [3:0]  queued_now,
  output logic        last
);

  // clamp for the buffer count register; it is only 4 bits wide
  localparam logic [3:0] ACT_CAP = (MAX_BUFFERS > 15) ? 4'd15 : 4'(MAX_BUFFERS);

  logic [3:0] buffers_in_use;
  logic [3:0] auto_queue_count;
  logic       keep_released;
  logic       cfg_wr;
  logic [1:0] reg_sel;

  fbom_pkg::cfg_t      cfg;
  fbom_pkg::cmd_item_t front_item;
  fbom_pkg::cmd_item_t q_item;
  logic                q_full;
  logic                q_not_empty;
  logic                q_pop;
  fbom_pkg::res_t      res;

  // register file: written on the access phase, read back combinationally
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffers_in_use   <= fbom_pkg::RST_BUFFERS_IN_USE;
      auto_queue_count <= fbom_pkg::RST_AUTO_QUEUE_COUNT;
      keep_released    <= fbom_pkg::RST_KEEP_RELEASED;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        fbom_pkg::REG_BUFFERS_IN_USE:   buffers_in_use   <= pwdata[3:0];
        fbom_pkg::REG_AUTO_QUEUE_COUNT: auto_queue_count <= pwdata[3:0];
        fbom_pkg::REG_KEEP_RELEASED:    keep_released    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fbom_pkg::REG_BUFFERS_IN_USE:   prdata = {28'd0, buffers_in_use};
      fbom_pkg::REG_AUTO_QUEUE_COUNT: prdata = {28'd0, auto_queue_count};
      fbom_pkg::REG_KEEP_RELEASED:    prdata = {31'd0, keep_released};
      default:                        prdata = '0;
    endcase
  end

  // effective buffer count: register clamped to what the block holds
  always_comb begin
    cfg.active           = (buffers_in_use > ACT_CAP) ? ACT_CAP : buffers_in_use;
    cfg.auto_queue_count = auto_queue_count;
    cfg.keep_released    = keep_released;
  end

  // front: decode and range-check the command word
  fbom_front u_front (
    .command      (command),
    .buffer_index (buffer_index),
    .active       (cfg.active),
    .item         (front_item)
  );

  assign cmd_ready = !q_full;

  fbom_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid && cmd_ready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_not_empty)
  );

  // back: owns the flags and counters, runs the rescan, drives result words
  fbom_back #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (q_not_empty),
    .item       (q_item),
    .item_pop   (q_pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign kind       = res.kind;
  assign out_index  = res.out_index;
  assign handle     = res.handle;
  assign status     = res.status;
  assign queued_now = res.queued_now;
  assign last       = res.last;

endmodule

// File: hdl/fbom_front.sv
module fbom_front (
  input  logic               [2:0] command,
  input  logic               [2:0] buffer_index,
  input  logic               [3:0] active,
  output fbom_pkg::cmd_item_t      item
);

  logic indexed;
  logic bad;

  always_comb begin
    indexed = command inside {fbom_pkg::CMD_FRAME_DONE, fbom_pkg::CMD_REQ_INDEX,
                              fbom_pkg::CMD_RELEASE};
    bad = indexed && ({1'b0, buffer_index} >= active);
    item.idx = buffer_index;
    if (bad) begin
      item.op = fbom_pkg::OP_BAD;
    end else begin
      unique case (command)
        fbom_pkg::CMD_FRAME_DONE: item.op = fbom_pkg::OP_FRAME_DONE;
        fbom_pkg::CMD_REQ_ANY:    item.op = fbom_pkg::OP_REQ_ANY;
        fbom_pkg::CMD_REQ_INDEX:  item.op = fbom_pkg::OP_REQ_INDEX;
        fbom_pkg::CMD_RELEASE:    item.op = fbom_pkg::OP_RELEASE;
        fbom_pkg::CMD_START:      item.op = fbom_pkg::OP_START;
        fbom_pkg::CMD_STOP:       item.op = fbom_pkg::OP_STOP;
        default:                  item.op = fbom_pkg::OP_NOP;
      endcase
    end
  end

endmodule

// File: hdl/fbom_cmd_fifo.sv
module fbom_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fbom_pkg::cmd_item_t push_item,
  output logic                full,
  input  logic                pop,
  output fbom_pkg::cmd_item_t pop_item,
  output logic                not_empty
);

  localparam int PW = (fbom_pkg::CMDQ_DEPTH > 1) ? $clog2(fbom_pkg::CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(fbom_pkg::CMDQ_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(fbom_pkg::CMDQ_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(fbom_pkg::CMDQ_DEPTH - 1);

  fbom_pkg::cmd_item_t entries [fbom_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == DEPTH_C);
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("cmd queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("cmd queue pop while empty");

endmodule

// File: hdl/fbom_back.sv
module fbom_back #(
  parameter int MAX_BUFFERS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  fbom_pkg::cfg_t      cfg,
  input  logic                item_valid,
  input  fbom_pkg::cmd_item_t item,
  output logic                item_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output fbom_pkg::res_t      res
);

  localparam int IW  = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int SIW = (IW > 4) ? IW : 4;
  localparam logic [3:0] SCAN_CAP = 4'(fbom_pkg::SCAN_ITEMS_MAX);

  fbom_pkg::bk_state_e state, state_next;
  fbom_pkg::op_e       op, op_next;
  logic [2:0]          idx, idx_next;
  logic [MAX_BUFFERS-1:0] queued, queued_next;
  logic [MAX_BUFFERS-1:0] released, released_next;
  logic [3:0]  queue_count, queue_count_next;
  logic [7:0]  pend_in, pend_in_next;
  logic [7:0]  pend_out, pend_out_next;
  logic [3:0]  auto_limit, auto_limit_next;
  logic [SIW-1:0] scan_i, scan_i_next;
  logic [3:0]  scan_cnt, scan_cnt_next;
  logic        res_valid_next;
  fbom_pkg::res_t res_next;

  logic           out_free;
  logic [IW-1:0]  ix;
  logic [IW-1:0]  si;
  logic           claim;
  logic [MAX_BUFFERS-1:0] act_mask;

  assign out_free = !res_valid || res_ready;
  assign ix = IW'(idx);
  assign si = scan_i[IW-1:0];

  always_comb begin
    for (int k = 0; k < MAX_BUFFERS; k++) begin
      act_mask[k] = (k < int'(cfg.active));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fbom_pkg::BK_IDLE;
      queued      <= '0;
      released    <= '1;
      queue_count <= '0;
      pend_in     <= '0;
      pend_out    <= '0;
      auto_limit  <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      queued      <= queued_next;
      released    <= released_next;
      queue_count <= queue_count_next;
      pend_in     <= pend_in_next;
      pend_out    <= pend_out_next;
      auto_limit  <= auto_limit_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    idx      <= idx_next;
    scan_i   <= scan_i_next;
    scan_cnt <= scan_cnt_next;
    res      <= res_next;
  end

  always_comb begin
    state_next       = state;
    op_next          = op;
    idx_next         = idx;
    queued_next      = queued;
    released_next    = released;
    queue_count_next = queue_count;
    pend_in_next     = pend_in;
    pend_out_next    = pend_out;
    auto_limit_next  = auto_limit;
    scan_i_next      = scan_i;
    scan_cnt_next    = scan_cnt;
    res_valid_next   = res_valid && !res_ready;
    res_next         = res;
    item_pop         = 1'b0;
    claim            = 1'b0;

    unique case (state)
      fbom_pkg::BK_IDLE: begin
        if (item_valid) begin
          item_pop      = 1'b1;
          op_next       = item.op;
          idx_next      = item.idx;
          scan_i_next   = '0;
          scan_cnt_next = '0;
          state_next    = fbom_pkg::BK_EXEC;
        end
      end

      fbom_pkg::BK_EXEC: begin
        unique case (op)
          fbom_pkg::OP_FRAME_DONE: begin
            if (out_free) begin
              claim = (pend_out != '0) && released[ix];
              if (claim) begin
                pend_out_next     = pend_out - 1'b1;
                released_next[ix] = 1'b0;
              end
              if (queue_count != '0) begin
                queue_count_next = queue_count - 1'b1;
              end
              queued_next[ix] = 1'b0;
              if (!released_next[ix]) begin
                res_valid_next      = 1'b1;
                res_next.kind       = fbom_pkg::KIND_NOTIFY;
                res_next.out_index  = idx;
                res_next.handle     = {1'b0, idx} + 4'd1;
                res_next.status     = fbom_pkg::STAT_OK;
                res_next.queued_now = queue_count_next;
                res_next.last       = 1'b0;
              end
              state_next = fbom_pkg::BK_SCAN;
            end
          end
          fbom_pkg::OP_REQ_ANY: begin
            if (pend_in != 8'hff) begin
              pend_in_next = pend_in + 1'b1;
            end
            if (pend_out != 8'hff) begin
              pend_out_next = pend_out + 1'b1;
            end
            state_next = fbom_pkg::BK_SCAN;
          end
          fbom_pkg::OP_REQ_INDEX: begin
            if (out_free) begin
              if (!queued[ix]) begin
                queued_next[ix] = 1'b1;
                if (queue_count != 4'hf) begin
                  queue_count_next = queue_count + 1'b1;
                end
                res_valid_next      = 1'b1;
                res_next.kind       = fbom_pkg::KIND_QUEUE;
                res_next.out_index  = idx;
                res_next.handle     = '0;
                res_next.status     = fbom_pkg::STAT_OK;
                res_next.queued_now = queue_count_next;
                res_next.last       = 1'b0;
              end
              released_next[ix] = 1'b0;
              state_next = fbom_pkg::BK_DONE;
            end
          end
          fbom_pkg::OP_RELEASE: begin
            released_next[ix] = 1'b1;
            state_next = fbom_pkg::BK_SCAN;
          end
          fbom_pkg::OP_START: begin
            auto_limit_next = cfg.auto_queue_count;
            state_next = fbom_pkg::BK_SCAN;
          end
          fbom_pkg::OP_STOP: begin
            auto_limit_next  = '0;
            queue_count_next = '0;
            pend_out_next    = '0;
            queued_next      = queued & ~act_mask;
            released_next    = released | (queued & act_mask);
            state_next = fbom_pkg::BK_DONE;
          end
          default: begin
            state_next = fbom_pkg::BK_DONE;
          end
        endcase
      end

      fbom_pkg::BK_SCAN: begin
        // one buffer per cycle unless the result port stalls; stops at active count, eight queue words or no work
        if (scan_i >= SIW'(cfg.active) || scan_cnt == SCAN_CAP) begin
          state_next = fbom_pkg::BK_DONE;
        end else if (pend_in == '0 && !(queue_count < auto_limit)) begin
          state_next = fbom_pkg::BK_DONE;
        end else if (!queued[si] && released[si]) begin
          if (out_free) begin
            queued_next[si]   = 1'b1;
            released_next[si] = released[si] && cfg.keep_released;
            if (queue_count != 4'hf) begin
              queue_count_next = queue_count + 1'b1;
            end
            if (pend_in != '0) begin
              pend_in_next = pend_in - 1'b1;
            end
            scan_cnt_next       = scan_cnt + 1'b1;
            scan_i_next         = scan_i + 1'b1;
            res_valid_next      = 1'b1;
            res_next.kind       = fbom_pkg::KIND_QUEUE;
            res_next.out_index  = 3'(scan_i);
            res_next.handle     = '0;
            res_next.status     = fbom_pkg::STAT_OK;
            res_next.queued_now = queue_count_next;
            res_next.last       = 1'b0;
          end
        end else begin
          scan_i_next = scan_i + 1'b1;
        end
      end

      fbom_pkg::BK_DONE: begin
        if (out_free) begin
          res_valid_next      = 1'b1;
          res_next.kind       = fbom_pkg::KIND_DONE;
          res_next.out_index  = '0;
          res_next.handle     = '0;
          res_next.queued_now = queue_count;
          res_next.last       = 1'b1;
          if (op == fbom_pkg::OP_BAD) begin
            res_next.status = fbom_pkg::STAT_BAD_INDEX;
          end else if (op == fbom_pkg::OP_REQ_ANY && scan_cnt == '0) begin
            res_next.status = fbom_pkg::STAT_RETRY;
          end else begin
            res_next.status = fbom_pkg::STAT_OK;
          end
          state_next = fbom_pkg::BK_IDLE;
        end
      end

      default: begin
        state_next = fbom_pkg::BK_IDLE;
      end
    endcase
  end

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == fbom_pkg::BK_DONE && out_free) |=> (res_valid && res.last))
    else $error("completion word not issued");
  a_scan_cap: assert property (@(posedge clk) disable iff (rst)
    (state == fbom_pkg::BK_SCAN) |-> (scan_cnt <= SCAN_CAP))
    else $error("scan issued too many queue words");
  a_notify_handle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == fbom_pkg::KIND_NOTIFY) |->
      (res.handle == {1'b0, res.out_index} + 4'd1 && !res.last))
    else $error("notify word handle mismatch");

endmodule
